[hdl/point_segment_distance_3d_assert.svh]
// Assertion macros for the block that checks itself
`ifndef POINT_SEGMENT_DISTANCE_3D_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_3D_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/psd_pkg.sv]
`default_nettype none
package psd_pkg;

  localparam int CoordW = 24;
  localparam int DiffW  = 25;
  localparam int ProdW  = 50;
  localparam int SumW   = 50;
  localparam int DotW   = 51;
  localparam int QiW    = 52;
  localparam int NqW    = 52;
  localparam int QtW    = 24;
  localparam int FourW  = 52;
  localparam int RootW  = 26;
  localparam int SremW  = 28;
  localparam int DistW  = 25;

  localparam int DivSteps  = 52;
  localparam int TSteps    = 24;
  localparam int SqrtSteps = 26;

  localparam logic signed [CoordW-1:0] ProjMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] ProjMin = 24'sh800000;
  localparam logic signed [CoordW-1:0] ProjOne = 24'sh010000;

  localparam logic [1:0] REG_BEFORE = 2'd0;
  localparam logic [1:0] REG_INSIDE = 2'd1;
  localparam logic [1:0] REG_BEYOND = 2'd2;
  localparam logic [1:0] REG_ZERO   = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0]         distance;
    logic signed [CoordW-1:0] proj_param;
    logic [1:0]               region;
  } out_t;

  // Division pipeline record: interior quotient and t quotient side by side
  typedef struct packed {
    logic [SumW-1:0]  len;
    logic [SumW-1:0]  rq;
    logic [NqW-1:0]   nq;
    logic [QiW-1:0]   qi;
    logic [SumW-1:0]  rt;
    logic [QtW-1:0]   nt;
    logic [QtW-1:0]   qt;
    logic             neg;
    logic             sat;
    logic [1:0]       region;
    logic [FourW-1:0] four_a;
    logic [FourW-1:0] four_b;
  } div_rec_t;

  // Square root pipeline record
  typedef struct packed {
    logic [FourW-1:0]         x;
    logic [RootW-1:0]         root;
    logic [SremW-1:0]         srem;
    logic signed [CoordW-1:0] t;
    logic [1:0]               region;
  } sq_rec_t;

endpackage
`default_nettype wire

[hdl/psd_front.sv]
`default_nettype none
module psd_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_valid,
  input  psd_pkg::in_t         in_data,
  output logic                 out_valid,
  output psd_pkg::div_rec_t    out_rec
);

  // stage 1: differences
  logic signed [psd_pkg::DiffW-1:0] sp_nxt [3];
  logic signed [psd_pkg::DiffW-1:0] se_nxt [3];
  logic signed [psd_pkg::DiffW-1:0] pe_nxt [3];
  logic signed [psd_pkg::DiffW-1:0] sp_r [3];
  logic signed [psd_pkg::DiffW-1:0] se_r [3];
  logic signed [psd_pkg::DiffW-1:0] pe_r [3];
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  always_comb begin
    logic signed [psd_pkg::CoordW-1:0] s [3];
    logic signed [psd_pkg::CoordW-1:0] e [3];
    logic signed [psd_pkg::CoordW-1:0] p [3];
    s[0] = in_data.start_x; s[1] = in_data.start_y; s[2] = in_data.start_z;
    e[0] = in_data.end_x;   e[1] = in_data.end_y;   e[2] = in_data.end_z;
    p[0] = in_data.point_x; p[1] = in_data.point_y; p[2] = in_data.point_z;
    for (int i = 0; i < 3; i++) begin
      sp_nxt[i] = {p[i][23], p[i]} - {s[i][23], s[i]};
      se_nxt[i] = {e[i][23], e[i]} - {s[i][23], s[i]};
      pe_nxt[i] = {e[i][23], e[i]} - {p[i][23], p[i]};
    end
  end

  // stage 2: products
  logic signed [psd_pkg::ProdW-1:0] pa_r [3];
  logic signed [psd_pkg::ProdW-1:0] pl_r [3];
  logic signed [psd_pkg::ProdW-1:0] pb_r [3];
  logic signed [psd_pkg::ProdW-1:0] pd_r [3];

  // stage 3: sums
  logic signed [psd_pkg::DotW-1:0] dot_r, dot_nxt;
  logic [psd_pkg::SumW-1:0]        a_r, len_r, b_r;

  always_comb begin
    logic signed [psd_pkg::DotW+1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      acc = acc + {{3{pd_r[i][psd_pkg::ProdW-1]}}, pd_r[i]};
    end
    dot_nxt = acc[psd_pkg::DotW-1:0];
  end

  // stage 4: classify, magnitude, saturation test
  logic [psd_pkg::SumW-1:0]  mag_r, mag_nxt, len4_r;
  logic                      neg4_r, sat4_r, sat_nxt;
  logic [1:0]                reg4_r, reg_nxt;
  logic [psd_pkg::FourW-1:0] fa4_r, fb4_r;

  always_comb begin
    logic [psd_pkg::DotW-1:0] absd;
    absd    = dot_r[psd_pkg::DotW-1] ? psd_pkg::DotW'(-dot_r) : dot_r;
    mag_nxt = absd[psd_pkg::SumW-1:0];
    sat_nxt = {7'b0, mag_nxt} >= {len_r, 7'b0};
    if (len_r == '0) begin
      reg_nxt = psd_pkg::REG_ZERO;
    end else if (dot_r[psd_pkg::DotW-1]) begin
      reg_nxt = psd_pkg::REG_BEFORE;
    end else if ({1'b0, mag_nxt} > {1'b0, len_r}) begin
      reg_nxt = psd_pkg::REG_BEYOND;
    end else begin
      reg_nxt = psd_pkg::REG_INSIDE;
    end
  end

  // stage 5: partial products of the squared dot product
  logic [psd_pkg::ProdW-1:0] hh_r, hl_r, ll_r;
  logic [psd_pkg::SumW-1:0]  mag5_r, len5_r;
  logic                      neg5_r, sat5_r;
  logic [1:0]                reg5_r;
  logic [psd_pkg::FourW-1:0] fa5_r, fb5_r;

  // stage 6: combine partial products and seed both dividers
  psd_pkg::div_rec_t rec_nxt;
  always_comb begin
    logic [99:0] msq;
    msq = {hh_r, ll_r} + 100'({hl_r, 26'b0});
    rec_nxt.len    = len5_r;
    rec_nxt.rq     = msq[99:50];
    rec_nxt.nq     = {msq[49:0], 2'b00};
    rec_nxt.qi     = '0;
    rec_nxt.rt     = {7'b0, mag5_r[49:7]};
    rec_nxt.nt     = {mag5_r[6:0], 17'b0};
    rec_nxt.qt     = '0;
    rec_nxt.neg    = neg5_r;
    rec_nxt.sat    = sat5_r;
    rec_nxt.region = reg5_r;
    rec_nxt.four_a = fa5_r;
    rec_nxt.four_b = fb5_r;
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r; out_valid <= v5_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sp_r[i] <= sp_nxt[i];
        se_r[i] <= se_nxt[i];
        pe_r[i] <= pe_nxt[i];
        pa_r[i] <= sp_r[i] * sp_r[i];
        pl_r[i] <= se_r[i] * se_r[i];
        pb_r[i] <= pe_r[i] * pe_r[i];
        pd_r[i] <= sp_r[i] * se_r[i];
      end
      dot_r  <= dot_nxt;
      a_r    <= pa_r[0][psd_pkg::SumW-1:0] + pa_r[1][psd_pkg::SumW-1:0]
              + pa_r[2][psd_pkg::SumW-1:0];
      len_r  <= pl_r[0][psd_pkg::SumW-1:0] + pl_r[1][psd_pkg::SumW-1:0]
              + pl_r[2][psd_pkg::SumW-1:0];
      b_r    <= pb_r[0][psd_pkg::SumW-1:0] + pb_r[1][psd_pkg::SumW-1:0]
              + pb_r[2][psd_pkg::SumW-1:0];
      mag_r  <= mag_nxt;
      len4_r <= len_r;
      neg4_r <= dot_r[psd_pkg::DotW-1];
      sat4_r <= sat_nxt;
      reg4_r <= reg_nxt;
      fa4_r  <= {a_r, 2'b00};
      fb4_r  <= {b_r, 2'b00};
      hh_r   <= mag_r[49:25] * mag_r[49:25];
      hl_r   <= mag_r[49:25] * mag_r[24:0];
      ll_r   <= mag_r[24:0] * mag_r[24:0];
      mag5_r <= mag_r;
      len5_r <= len4_r;
      neg5_r <= neg4_r;
      sat5_r <= sat4_r;
      reg5_r <= reg4_r;
      fa5_r  <= fa4_r;
      fb5_r  <= fb4_r;
      out_rec <= rec_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/psd_div_stage.sv]
`default_nettype none
module psd_div_stage #(
  parameter bit T_STEP = 1'b1
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                in_valid,
  input  psd_pkg::div_rec_t  in_rec,
  output logic               out_valid,
  output psd_pkg::div_rec_t  out_rec
);

  psd_pkg::div_rec_t rec_nxt;

  // one restoring step for the squared-dot quotient, one for t when enabled
  always_comb begin
    logic [psd_pkg::SumW:0] rx, tx;
    logic                   gi, gt;
    rec_nxt = in_rec;
    rx = {in_rec.rq, in_rec.nq[psd_pkg::NqW-1]};
    gi = rx >= {1'b0, in_rec.len};
    rec_nxt.rq = gi ? psd_pkg::SumW'(rx - {1'b0, in_rec.len}) : rx[psd_pkg::SumW-1:0];
    rec_nxt.nq = {in_rec.nq[psd_pkg::NqW-2:0], 1'b0};
    rec_nxt.qi = {in_rec.qi[psd_pkg::QiW-2:0], gi};
    tx = {in_rec.rt, in_rec.nt[psd_pkg::QtW-1]};
    gt = tx >= {1'b0, in_rec.len};
    if (T_STEP) begin
      rec_nxt.rt = gt ? psd_pkg::SumW'(tx - {1'b0, in_rec.len}) : tx[psd_pkg::SumW-1:0];
      rec_nxt.nt = {in_rec.nt[psd_pkg::QtW-2:0], 1'b0};
      rec_nxt.qt = {in_rec.qt[psd_pkg::QtW-2:0], gt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec <= rec_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/psd_sqrt_stage.sv]
`default_nettype none
module psd_sqrt_stage (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               en,
  input  wire               in_valid,
  input  psd_pkg::sq_rec_t  in_rec,
  output logic              out_valid,
  output psd_pkg::sq_rec_t  out_rec
);

  psd_pkg::sq_rec_t rec_nxt;

  // take two radicand bits, try 4*root+1 against the remainder
  always_comb begin
    logic [psd_pkg::SremW+1:0] rx;
    logic [psd_pkg::SremW+1:0] trial;
    logic                      ge;
    rec_nxt = in_rec;
    rx    = {in_rec.srem, in_rec.x[psd_pkg::FourW-1 -: 2]};
    trial = {2'b00, in_rec.root, 2'b01};
    ge    = rx >= trial;
    rec_nxt.srem = ge ? psd_pkg::SremW'(rx - trial) : rx[psd_pkg::SremW-1:0];
    rec_nxt.root = {in_rec.root[psd_pkg::RootW-2:0], ge};
    rec_nxt.x    = {in_rec.x[psd_pkg::FourW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rec <= rec_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/point_segment_distance_3d.sv]
// Pipeline: an accepted request reaches the output register through
// 6 front stages, 52 quotient steps, 1 select stage, 26 root steps and 1 output stage.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous active-low rst_n clears every valid bit; payload is not reset.
`default_nettype none
`include "point_segment_distance_3d_assert.svh"
module point_segment_distance_3d (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  psd_pkg::in_t   in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output psd_pkg::out_t  out_data
);

  logic en;
  logic out_valid_r;
  psd_pkg::out_t out_data_r;

  // hold everything while a result is refused
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic              dval [psd_pkg::DivSteps+1];
  psd_pkg::div_rec_t drec [psd_pkg::DivSteps+1];

  psd_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_data(in_data),
    .out_valid(dval[0]), .out_rec(drec[0])
  );

  // quotient chain: t finishes in the first steps, the squared-dot term runs on
  for (genvar k = 0; k < psd_pkg::DivSteps; k++) begin : g_div
    psd_div_stage #(.T_STEP(k < psd_pkg::TSteps)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(dval[k]), .in_rec(drec[k]),
      .out_valid(dval[k+1]), .out_rec(drec[k+1])
    );
  end

  // select stage: round or saturate t, pick four times the squared distance
  psd_pkg::div_rec_t dq;
  psd_pkg::sq_rec_t  sel_nxt;
  assign dq = drec[psd_pkg::DivSteps];

  always_comb begin
    logic [psd_pkg::QiW-1:0]   sub;
    logic [psd_pkg::QtW:0]     qt1;
    logic [psd_pkg::QtW-1:0]   qr;
    sub = dq.qi + psd_pkg::QiW'(dq.rq != '0);
    qt1 = {1'b0, dq.qt} + 1'b1;
    qr  = qt1[psd_pkg::QtW:1];
    if (dq.region == psd_pkg::REG_ZERO) begin
      sel_nxt.t = '0;
    end else if (dq.sat) begin
      sel_nxt.t = dq.neg ? psd_pkg::ProjMin : psd_pkg::ProjMax;
    end else if (dq.neg) begin
      sel_nxt.t = -$signed(qr);
    end else begin
      sel_nxt.t = qr[psd_pkg::QtW-1] ? psd_pkg::ProjMax : $signed(qr);
    end
    case (dq.region)
      psd_pkg::REG_INSIDE: sel_nxt.x = (dq.four_a >= sub) ? dq.four_a - sub : '0;
      psd_pkg::REG_BEYOND: sel_nxt.x = dq.four_b;
      default:             sel_nxt.x = dq.four_a;
    endcase
    sel_nxt.root   = '0;
    sel_nxt.srem   = '0;
    sel_nxt.region = dq.region;
  end

  logic             sval [psd_pkg::SqrtSteps+1];
  psd_pkg::sq_rec_t srec [psd_pkg::SqrtSteps+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sval[0] <= 1'b0;
    end else if (en) begin
      sval[0] <= dval[psd_pkg::DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srec[0] <= sel_nxt;
    end
  end

  for (genvar k = 0; k < psd_pkg::SqrtSteps; k++) begin : g_sqrt
    psd_sqrt_stage u_sqrt (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(sval[k]), .in_rec(srec[k]),
      .out_valid(sval[k+1]), .out_rec(srec[k+1])
    );
  end

  // output register: round the root to the Q.16 distance
  psd_pkg::sq_rec_t sf;
  psd_pkg::out_t    out_nxt;
  assign sf = srec[psd_pkg::SqrtSteps];

  always_comb begin
    logic [psd_pkg::RootW:0] r1;
    r1 = {1'b0, sf.root} + 1'b1;
    out_nxt.distance   = r1[psd_pkg::DistW:1];
    out_nxt.proj_param = sf.t;
    out_nxt.region     = sf.region;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sval[psd_pkg::SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  // self checks
  `PSD_ASSERT_NOW(a_stall_only_on_refusal, !in_ready, out_valid && !out_ready, "stall without refusal")
  `PSD_ASSERT_NOW(a_zero_len_t, out_valid && out_data.region == psd_pkg::REG_ZERO, out_data.proj_param == '0, "zero-length t not zero")
  `PSD_ASSERT_NOW(a_inside_t, out_valid && out_data.region == psd_pkg::REG_INSIDE, !out_data.proj_param[23] && out_data.proj_param <= psd_pkg::ProjOne, "interior t out of range")
  `PSD_ASSERT_NOW(a_before_t, out_valid && out_data.region == psd_pkg::REG_BEFORE, out_data.proj_param[23] || out_data.proj_param == '0, "before-start t positive")

endmodule
`default_nettype wire

[tb/point_segment_distance_3d_tb.sv]
`default_nettype none
module point_segment_distance_3d_tb;

  // Exact integer model of the distance, t and region for one request
  function automatic psd_pkg::out_t segment_distance(psd_pkg::in_t r);
    logic signed [63:0] s[3], e[3], p[3];
    logic signed [63:0] sp, se, pe, dot, sa, len, sb;
    logic [127:0] mag, num, sub, rem;
    logic [63:0] q, four_s, x, res, bit_w;
    logic signed [63:0] t;
    logic [1:0] region;
    psd_pkg::out_t o;
    s[0] = r.start_x; s[1] = r.start_y; s[2] = r.start_z;
    e[0] = r.end_x;   e[1] = r.end_y;   e[2] = r.end_z;
    p[0] = r.point_x; p[1] = r.point_y; p[2] = r.point_z;
    dot = 0; sa = 0; len = 0; sb = 0;
    for (int i = 0; i < 3; i++) begin
      sp = p[i] - s[i];
      se = e[i] - s[i];
      pe = e[i] - p[i];
      dot += sp * se;
      sa += sp * sp;
      len += se * se;
      sb += pe * pe;
    end
    if (len == 0) begin
      region = psd_pkg::REG_ZERO;
      t = 0;
      four_s = 4 * sa;
    end else begin
      mag = (dot < 0) ? -dot : dot;
      if (mag >= 128 * len) begin
        t = (dot < 0) ? -64'sd8388608 : 64'sd8388607;
      end else begin
        q = ((mag << 17) / len + 1) >> 1;
        t = (dot < 0) ? -$signed(q) : $signed(q);
        if (t > 64'sd8388607) t = 64'sd8388607;
        if (t < -64'sd8388608) t = -64'sd8388608;
      end
      if (dot < 0) begin
        region = psd_pkg::REG_BEFORE;
        four_s = 4 * sa;
      end else if (dot > len) begin
        region = psd_pkg::REG_BEYOND;
        four_s = 4 * sb;
      end else begin
        region = psd_pkg::REG_INSIDE;
        num = (2 * mag) * (2 * mag);
        sub = num / len;
        rem = num % len;
        if (rem != 0) sub++;
        four_s = (4 * sa >= sub) ? 4 * sa - sub : 0;
      end
    end
    // Integer square root, bit by bit
    x = four_s;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    o.distance = psd_pkg::DistW'((res + 1) >> 1);
    o.proj_param = t[23:0];
    o.region = region;
    return o;
  endfunction

  class distance_scoreboard;
    psd_pkg::out_t pending[$];
    int errors = 0;
    int checked = 0;
    int region_hits[4];

    function void note_request(psd_pkg::in_t r);
      pending.push_back(segment_distance(r));
    endfunction

    function void check_result(psd_pkg::out_t got);
      psd_pkg::out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      region_hits[exp.region]++;
      if (got.distance !== exp.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, exp.distance, got.distance);
        errors++;
      end
      if (got.proj_param !== exp.proj_param) begin
        $display("%0t: proj_param expected %0d actual %0d", $time,
                 exp.proj_param, got.proj_param);
        errors++;
      end
      if (got.region !== exp.region) begin
        $display("%0t: region expected %0d actual %0d", $time, exp.region, got.region);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  psd_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  psd_pkg::out_t out_data;

  distance_scoreboard board = new();
  bit steady = 0;
  bit hold_off = 0;
  bit sending_done = 0;
  int quiet_cycles = 0;

  localparam int QuietLimit = 5000;

  point_segment_distance_3d i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Note accepted requests, check results, watch for a stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_request(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive out_ready: random stalls, quiet stretch, one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else if (steady) out_ready <= 1;
    else out_ready <= ($urandom_range(99) >= 14);
  end

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return $signed(24'($urandom_range(511))) - 24'sd256;
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(psd_pkg::in_t r);
    if (!steady) begin
      while ($urandom_range(99) < 14) begin
        in_valid <= 0;
        @(negedge clk);
      end
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    psd_pkg::in_t r;
    logic signed [23:0] d;
    for (int k = 0; k < n; k++) begin
      r = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord(), rand_coord(), rand_coord(), rand_coord()};
      case ($urandom_range(7))
        // zero-length segment
        0: {r.end_x, r.end_y, r.end_z} = {r.start_x, r.start_y, r.start_z};
        // end_x and point_x near start_x
        1: begin
          d = $signed(24'($urandom_range(7))) - 24'sd3;
          r.end_x = r.start_x + d;
          r.point_x = r.start_x + $signed(24'($urandom_range(15))) - 24'sd7;
        end
        // point on the segment's end or start
        2: {r.point_x, r.point_y, r.point_z} = {r.end_x, r.end_y, r.end_z};
        3: {r.point_x, r.point_y, r.point_z} = {r.start_x, r.start_y, r.start_z};
        default: ;
      endcase
      send_request(r);
    end
  endtask

  task automatic send_directed();
    psd_pkg::in_t r;
    // zero-length, interior, before, beyond, t exactly 0 and 1, saturation
    send_request('0);
    r = '0; r.end_x = 24'sh010000; r.point_x = 24'sh008000; r.point_y = 24'sh010000;
    send_request(r);
    r.point_x = -24'sh010000; send_request(r);
    r.point_x = 24'sh030000; send_request(r);
    r.point_x = 24'sh000000; send_request(r);
    r.point_x = 24'sh010000; send_request(r);
    r = '0; r.end_x = 24'sd1; r.point_x = 24'sh7FFFFF; send_request(r);
    r.point_x = 24'sh800000; send_request(r);
    r = '0; r.end_x = 24'sd1; r.point_x = 24'sd1; r.point_y = 24'sd1; send_request(r);
    r = {9{24'sh7FFFFF}}; send_request(r);
    r = {9{24'sh800000}}; send_request(r);
    r = {24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
         24'sh800000, 24'sh7FFFFF, 24'sh000000};
    send_request(r);
    r = {24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
         24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
    send_request(r);
    r = {24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
         24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
    send_request(r);
    r = '0; r.start_x = 24'sh800000; r.end_x = 24'sh7FFFFF; r.point_y = 24'sh7FFFFF;
    send_request(r);
    r = '0; r.end_y = -24'sd3; r.point_y = -24'sd1; r.point_z = 24'sd1; send_request(r);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_directed();
    send_random(700);
    // Hold the output while requests keep coming to fill the pipeline
    hold_off = 1;
    fork
      send_random(150);
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
    join
    steady = 1;
    send_random(300);
    steady = 0;
    send_random(700);
    in_valid <= 0;
    sending_done = 1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("checked %0d results: %0d before, %0d interior, %0d beyond, %0d zero-length",
             board.checked, board.region_hits[0], board.region_hits[1],
             board.region_hits[2], board.region_hits[3]);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

[point_segment_distance_3d.f]
+incdir+hdl
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_div_stage.sv
hdl/psd_sqrt_stage.sv
hdl/point_segment_distance_3d.sv
tb/point_segment_distance_3d_tb.sv
